/* rtl/dnsqb_pkg.sv */
// Shared types and constants for the DNS query message builder.
// No dependencies; imported by dns_query_message_builder.
package dnsqb_pkg;

    localparam int MAX_LABEL = 32;  // bytes held per label, 1..63
    localparam int CNT_W     = $clog2(MAX_LABEL + 1);
    localparam int ADDR_W    = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

    localparam logic [7:0]  DOT_CHAR      = 8'h2E;
    localparam logic [15:0] QDCOUNT_ONE   = 16'h0001;
    localparam logic [15:0] RST_QTYPE     = 16'h0001;
    localparam logic [15:0] RST_QCLASS    = 16'h0001;
    localparam logic [15:0] RST_FLAGS     = 16'h0100;

    localparam logic [3:0]  HDR_LEN       = 4'd12;
    localparam logic [3:0]  TAIL_LEN      = 4'd5;

    localparam logic [1:0]  REG_QTYPE     = 2'd0;
    localparam logic [1:0]  REG_QCLASS    = 2'd1;
    localparam logic [1:0]  REG_FLAGS     = 2'd2;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_CHAR  = 2'd1,
        CMD_END   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_LEN,
        ST_CHARS,
        ST_TAIL
    } t_state;

endpackage

/* rtl/dns_query_message_builder.sv */
// DNS single-question query message builder: header, labels, type and class.
// Depends on dnsqb_pkg; holds the label memory internally.
//
//  channel   direction  signals                                         moves
//  in        in         i_in_valid/o_in_ready, command, id, char        one command
//  out       out        o_out_valid/i_out_ready, byte, final, too_long  one message byte
//  cfg       in         psel/penable/pwrite/paddr/pwdata/prdata/pready  register access
//
// A name character or an ignored command is taken while idle. A start sends the
// 12 header bytes, an end flushes any pending label and then sends the 5 tail bytes,
// and a flushing dot sends the length byte and the n bytes of an n-byte label; no new
// command is taken until these are sent. The output register moves one byte per cycle
// while not stalled, and the label memory gives one byte per cycle through its single
// registered read port. Reset is synchronous; the label memory is never cleared, since
// only entries written in the current label are read. A stalled output holds the sequencer.
module dns_query_message_builder
    import dnsqb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_query_id,
    input  logic [7:0]  i_name_char,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_wire_byte,
    output logic        o_final_byte,
    output logic        o_label_too_long,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]        label_store [MAX_LABEL];

    t_state            r_state, n_state;
    logic [3:0]        r_step, n_step;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_overflow, n_overflow;
    logic              r_end, n_end;
    logic [15:0]       r_id, n_id;
    logic [7:0]        r_rd_data;

    logic [15:0]       r_qtype, r_qclass, r_flags;

    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_final;
    logic              r_out_tl;

    logic              in_xfer, out_free, emit;
    logic [7:0]        e_byte;
    logic              e_final, e_tl;
    logic              mem_we;
    logic              last_char;
    t_cmd              cmd;

    assign cmd       = t_cmd'(i_command);
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer   = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_char = (CNT_W'(r_idx) == r_count - CNT_W'(1));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qtype  <= RST_QTYPE;
            r_qclass <= RST_QCLASS;
            r_flags  <= RST_FLAGS;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_QTYPE:  r_qtype  <= pwdata[15:0];
                REG_QCLASS: r_qclass <= pwdata[15:0];
                REG_FLAGS:  r_flags  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_QTYPE:  prdata = {16'd0, r_qtype};
            REG_QCLASS: prdata = {16'd0, r_qclass};
            REG_FLAGS:  prdata = {16'd0, r_flags};
            default:    prdata = 32'd0;
        endcase
    end

    // Next state
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_idx      = r_idx;
        n_count    = r_count;
        n_overflow = r_overflow;
        n_end      = r_end;
        n_id       = r_id;
        mem_we     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (cmd)
                        CMD_START: begin
                            n_count    = '0;
                            n_overflow = 1'b0;
                            n_id       = i_query_id;
                            n_step     = '0;
                            n_state    = ST_HDR;
                        end
                        CMD_CHAR: begin
                            if (i_name_char == DOT_CHAR) begin
                                n_end = 1'b0;
                                n_idx = '0;
                                if (r_count != '0) begin
                                    n_state = ST_LEN;
                                end else begin
                                    n_overflow = 1'b0;
                                end
                            end else if (r_count < CNT_W'(MAX_LABEL)) begin
                                mem_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_overflow = 1'b1;
                            end
                        end
                        CMD_END: begin
                            n_end  = 1'b1;
                            n_idx  = '0;
                            n_step = '0;
                            if (r_count != '0) begin
                                n_state = ST_LEN;
                            end else begin
                                n_overflow = 1'b0;
                                n_state    = ST_TAIL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_HDR: begin
                if (emit) begin
                    n_step = r_step + 4'd1;
                    if (r_step == HDR_LEN - 4'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_LEN: begin
                if (emit) begin
                    n_state = ST_CHARS;
                end
            end
            ST_CHARS: begin
                if (emit) begin
                    if (last_char) begin
                        // Label done: drop it and move on
                        n_idx      = '0;
                        n_count    = '0;
                        n_overflow = 1'b0;
                        n_step     = '0;
                        n_state    = r_end ? ST_TAIL : ST_IDLE;
                    end else begin
                        n_idx = r_idx + ADDR_W'(1);
                    end
                end
            end
            ST_TAIL: begin
                if (emit) begin
                    n_step = r_step + 4'd1;
                    if (r_step == TAIL_LEN - 4'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Byte generation
    always_comb begin
        emit    = 1'b0;
        e_byte  = 8'd0;
        e_final = 1'b0;
        e_tl    = 1'b0;
        case (r_state)
            ST_HDR: begin
                emit = out_free;
                case (r_step)
                    4'd0:    e_byte = r_id[15:8];
                    4'd1:    e_byte = r_id[7:0];
                    4'd2:    e_byte = r_flags[15:8];
                    4'd3:    e_byte = r_flags[7:0];
                    4'd4:    e_byte = QDCOUNT_ONE[15:8];
                    4'd5:    e_byte = QDCOUNT_ONE[7:0];
                    default: e_byte = 8'd0;
                endcase
            end
            ST_LEN: begin
                emit   = out_free;
                e_byte = 8'(r_count);
                e_tl   = r_overflow;
            end
            ST_CHARS: begin
                emit   = out_free;
                e_byte = r_rd_data;
            end
            ST_TAIL: begin
                emit = out_free;
                case (r_step)
                    4'd1:    e_byte = r_qtype[15:8];
                    4'd2:    e_byte = r_qtype[7:0];
                    4'd3:    e_byte = r_qclass[15:8];
                    4'd4:    e_byte = r_qclass[7:0];
                    default: e_byte = 8'd0;
                endcase
                e_final = (r_step == TAIL_LEN - 4'd1);
            end
            default: ;
        endcase
    end

    // Label memory: read address follows the next index so r_rd_data always
    // matches r_idx. Writes happen only in idle, so they are done before a flush starts.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            label_store[r_count[ADDR_W-1:0]] <= i_name_char;
        end
        r_rd_data <= label_store[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_step     <= '0;
            r_idx      <= '0;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_end      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_idx      <= n_idx;
            r_count    <= n_count;
            r_overflow <= n_overflow;
            r_end      <= n_end;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_id <= n_id;
        if (emit) begin
            r_out_byte  <= e_byte;
            r_out_final <= e_final;
            r_out_tl    <= e_tl;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_wire_byte      = r_out_byte;
    assign o_final_byte     = r_out_final;
    assign o_label_too_long = r_out_tl;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LABEL))
        else $error("label count beyond buffer size");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_count == CNT_W'(MAX_LABEL)))
        else $error("overflow flagged on a label that is not full");

    a_idx_in_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHARS) |-> (CNT_W'(r_idx) < r_count))
        else $error("label read index past stored characters");

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEN) |-> (r_count != '0))
        else $error("length byte for an empty label");

endmodule
